// File: design/tsbq_pkg.sv
// ----------------------------------------------------------------------------
// TLB shootdown batch queue package
// Command codes, input kinds and controller state type shared by the block.
// ----------------------------------------------------------------------------
package tsbq_pkg;

	typedef enum logic [1:0] {
		CMD_LOCAL_PAGE   = 2'd0,
		CMD_REMOTE_PAGE  = 2'd1,
		CMD_FLUSH_CTX    = 2'd2,
		CMD_FLUSH_GLOBAL = 2'd3
	} cmd_t;

	localparam logic KIND_QUEUE  = 1'b0;
	localparam logic KIND_COMMIT = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

// File: design/tsbq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and holds
// its value until the next read is enabled.
// ----------------------------------------------------------------------------
module tsbq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/tlb_shootdown_batch_queue_core.sv
// ----------------------------------------------------------------------------
// TLB shootdown batch queue
// Collects page invalidations and replays them as a remote command run or one flush command.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall) carries kind, addr and global_page.
// A queue transfer gives one local invalidate result in the next cycle and
// stores the address in the pending RAM, or enters flush-all mode when the
// RAM is full or flush-all mode is already active. Queue transfers are
// taken every cycle while idle and the output register drains.
// A commit transfer with work pending gives either one flush command or one
// remote invalidate per stored address, oldest first. A drain reads the RAM
// once per cycle while out_stall does not hold it, and in_stall stays high
// until the last result has moved into the output register.
// The output channel (out_valid, out_stall) is fed from one output register;
// while out_stall is high on a valid output, the register and the RAM read stage hold.
// Reset clears the count, flush-all mode and global flag at once; the RAM
// holds no reset state and only written entries are ever read.
// ----------------------------------------------------------------------------
module tlb_shootdown_batch_queue_core #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [63:0]         addr,
	input  logic                global_page,
	output logic                out_valid,
	input  logic                out_stall,
	output tsbq_pkg::cmd_t      command,
	output logic [63:0]         page_address,
	output logic                last
);

	import tsbq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q;
	logic          flush_q;
	logic          global_q;
	logic [CW-1:0] rd_ptr_q;
	logic [CW-1:0] rd_ptr_nxt;
	logic          s1_valid_q;
	logic          s1_last_q;
	logic          out_valid_q;
	cmd_t          command_q;
	logic [63:0]   page_address_q;
	logic          last_q;

	logic          out_ready;
	logic          in_take;
	logic          take_queue;
	logic          take_commit;
	logic          commit_flush;
	logic          commit_drain;
	logic          rd_en;
	logic          s1_move;
	logic          wr_en;
	logic [63:0]   rd_data;

	assign out_ready    = !out_valid_q || !out_stall;
	assign in_take      = in_valid && !in_stall;
	assign take_queue   = in_take && (kind == KIND_QUEUE);
	assign take_commit  = in_take && (kind == KIND_COMMIT);
	assign commit_flush = take_commit && flush_q;
	assign commit_drain = take_commit && !flush_q && (count_q != '0);
	assign wr_en        = take_queue && !flush_q && (count_q != FULL_COUNT);
	assign rd_ptr_nxt   = rd_ptr_q + CW'(1);
	assign s1_move      = s1_valid_q && out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (commit_drain) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (s1_move && s1_last_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = !out_ready;
			end
			ST_DRAIN: begin
				rd_en = (rd_ptr_q != count_q) && (!s1_valid_q || out_ready);
			end
			default: begin
				in_stall = 1'b1;
				rd_en    = 1'b0;
			end
		endcase
	end

	tsbq_ram #(
		.WIDTH (64),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (addr),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr_q[IW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			flush_q    <= 1'b0;
			global_q   <= 1'b0;
			rd_ptr_q   <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_queue) begin
				if (global_page) begin
					global_q <= 1'b1;
				end
				if (count_q == FULL_COUNT) begin
					flush_q <= 1'b1;
				end
				if (wr_en) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (commit_flush || (s1_move && s1_last_q)) begin
				count_q  <= '0;
				flush_q  <= 1'b0;
				global_q <= 1'b0;
			end
			if (commit_drain) begin
				rd_ptr_q <= '0;
			end else if (rd_en) begin
				rd_ptr_q <= rd_ptr_nxt;
			end
			if (rd_en) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			s1_last_q <= (rd_ptr_nxt == count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= take_queue || commit_flush || s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			if (take_queue) begin
				command_q      <= CMD_LOCAL_PAGE;
				page_address_q <= addr;
				last_q         <= 1'b1;
			end else if (commit_flush) begin
				command_q      <= global_q ? CMD_FLUSH_GLOBAL : CMD_FLUSH_CTX;
				page_address_q <= '0;
				last_q         <= 1'b1;
			end else if (s1_valid_q) begin
				command_q      <= CMD_REMOTE_PAGE;
				page_address_q <= rd_data;
				last_q         <= s1_last_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign command      = command_q;
	assign page_address = page_address_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_s1_only_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> (state_q == ST_DRAIN))
		else $error("Read stage holds data outside a drain.");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("Pending count exceeds the queue depth.");

	a_no_input_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> in_stall)
		else $error("Input transfer possible during a drain.");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_ptr_q < count_q))
		else $error("RAM read beyond the stored entries.");

	a_drain_ends_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && s1_last_q) |=> ((count_q == '0) && !global_q && (state_q == ST_IDLE)))
		else $error("Drain ended without clearing the batch.");
`endif

endmodule

// File: bench/tlb_shootdown_batch_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB shootdown batch queue testbench
// Drives queue and commit transfers through the input channel and checks
// every output transfer against a behavioural tracker of the pending store,
// the flush-all mode and the global flag. Phases vary sender gaps and
// receiver stalls, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tlb_shootdown_batch_queue_core_tb;
	import tsbq_pkg::*;

	localparam int QDEPTH      = 64;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		cmd_t        command;
		logic [63:0] page;
		logic        last;
	} shootdown_cmd_t;

	class shootdown_tracker;
		shootdown_cmd_t expected_cmds[$];
		logic [63:0]    batch_addr [QDEPTH];
		int unsigned    batch_count = 0;
		bit             overflowed  = 1'b0;
		bit             saw_global  = 1'b0;
		int             mismatches  = 0;
		int             checked     = 0;
		int             flushes     = 0;
		int             full_drains = 0;

		function void expect_cmd(cmd_t c, logic [63:0] p, logic l);
			shootdown_cmd_t item;
			item.command = c;
			item.page    = p;
			item.last    = l;
			expected_cmds.push_back(item);
		endfunction

		function void note_request(logic k, logic [63:0] a, logic g);
			if (k == KIND_QUEUE) begin
				expect_cmd(CMD_LOCAL_PAGE, a, 1'b1);
				if (g)
					saw_global = 1'b1;
				if (batch_count >= QDEPTH)
					overflowed = 1'b1;
				if (!overflowed) begin
					batch_addr[batch_count] = a;
					batch_count++;
				end
			end else if (overflowed || batch_count != 0) begin
				if (overflowed) begin
					expect_cmd(saw_global ? CMD_FLUSH_GLOBAL : CMD_FLUSH_CTX, 64'd0, 1'b1);
					flushes++;
				end else begin
					for (int i = 0; i < batch_count; i++)
						expect_cmd(CMD_REMOTE_PAGE, batch_addr[i], i + 1 == batch_count);
					if (batch_count == QDEPTH)
						full_drains++;
				end
				batch_count = 0;
				overflowed  = 1'b0;
				saw_global  = 1'b0;
			end
		endfunction

		function void check_command(cmd_t c, logic [63:0] p, logic l);
			shootdown_cmd_t want;
			checked++;
			if (expected_cmds.size() == 0) begin
				if (mismatches < 10)
					$display("Unexpected result: command %0d page %h last %b", c, p, l);
				mismatches++;
				return;
			end
			want = expected_cmds.pop_front();
			if (want.command !== c || want.page !== p || want.last !== l) begin
				if (mismatches < 10)
					$display("Mismatch: expected command %0d page %h last %b, got %0d %h %b",
						want.command, want.page, want.last, c, p, l);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic        kind         = KIND_QUEUE;
	logic [63:0] addr         = 64'd0;
	logic        global_page  = 1'b0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	cmd_t        command;
	logic [63:0] page_address;
	logic        last;

	logic        hold_on        = 1'b0;
	int          sender_idle_pct = 0;
	int          recv_stall_pct  = 0;
	int          items_sent      = 0;
	int          cycle_count     = 0;

	shootdown_tracker tracker = new();

	tlb_shootdown_batch_queue_core #(
		.QUEUE_DEPTH(QDEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.addr        (addr),
		.global_page (global_page),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.command     (command),
		.page_address(page_address),
		.last        (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL tlb_shootdown_batch_queue_core");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_command(command, page_address, last);
		out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_request(logic k, logic [63:0] a, logic g);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		addr        <= a;
		global_page <= g;
		do
			@(posedge clk);
		while (in_stall);
		tracker.note_request(k, a, g);
		items_sent++;
	endtask

	task automatic queue_batch(int n, int global_pct);
		repeat (n)
			send_request(KIND_QUEUE, {$urandom, $urandom}, $urandom_range(99) < global_pct);
		send_request(KIND_COMMIT, {$urandom, $urandom}, 1'($urandom_range(1)));
	endtask

	initial begin
		int phase_end;
		int pick;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Extreme addresses and both global values, then commits with and without entries pending.
		send_request(KIND_QUEUE, 64'd0, 1'b0);
		send_request(KIND_QUEUE, {64{1'b1}}, 1'b1);
		send_request(KIND_QUEUE, 64'h8000_0000_0000_0001, 1'b0);
		send_request(KIND_COMMIT, 64'd0, 1'b0);
		send_request(KIND_COMMIT, {64{1'b1}}, 1'b1);
		send_request(KIND_QUEUE, 64'h5555_5555_5555_5555, 1'b1);
		send_request(KIND_COMMIT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_request(KIND_QUEUE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_request(KIND_QUEUE, 64'h5555_5555_5555_5555, 1'b0);
		send_request(KIND_COMMIT, 64'h0, 1'b1);
		send_request(KIND_COMMIT, 64'h0, 1'b0);

		// The receiver holds off while the sender keeps offering transfers.
		fork
			begin
				hold_on <= 1'b1;
				repeat (150) @(posedge clk);
				hold_on <= 1'b0;
			end
		join_none
		queue_batch(6, 15);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin sender_idle_pct = 0;  recv_stall_pct <= 0;  end
				1: begin sender_idle_pct = 63; recv_stall_pct <= 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct <= 63; end
				default: begin sender_idle_pct = 23; recv_stall_pct <= 23; end
			endcase
			case (ph)
				1: queue_batch(QDEPTH + 1, 0);
				2: queue_batch(QDEPTH, 10);
				3: queue_batch(QDEPTH + 1, 100);
				default: ;
			endcase
			phase_end = items_sent + 5;
			while (items_sent < phase_end) begin
				pick = $urandom_range(99);
				if (pick < 15)
					send_request(KIND_COMMIT, {$urandom, $urandom}, 1'($urandom_range(1)));
				else
					queue_batch($urandom_range(6), 15);
			end
		end

		in_valid <= 1'b0;
		while (tracker.expected_cmds.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d input transfers and checked %0d result transfers.",
			items_sent, tracker.checked);
		$display("Covered %0d full-store drains and %0d flush commands after overflow.",
			tracker.full_drains, tracker.flushes);
		if (tracker.mismatches == 0 && tracker.expected_cmds.size() == 0)
			$display("PASS tlb_shootdown_batch_queue_core");
		else
			$display("FAIL tlb_shootdown_batch_queue_core");
		$finish;
	end

endmodule
